// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define TES_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("text_encoding_sniffer check failed");

// Clocked implication check, off while reset is asserted.
`define TES_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text_encoding_sniffer implication failed");

`endif

// File: sv/tes_pkg.sv
package tes_pkg;

	localparam logic [1:0] BOM_NONE  = 2'd0;
	localparam logic [1:0] BOM_UTF8  = 2'd1;
	localparam logic [1:0] BOM_LE    = 2'd2;
	localparam logic [1:0] BOM_BE    = 2'd3;

	localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
	localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
	localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
	localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
	localparam logic [15:0] NON_CHAR    = 16'hFFFF;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_BITS  = 8'h80;

	localparam logic [7:0] BOM8_B0 = 8'hEF;
	localparam logic [7:0] BOM8_B1 = 8'hBB;
	localparam logic [7:0] BOM8_B2 = 8'hBF;
	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic [7:0] BYTE_FE = 8'hFE;

	typedef struct packed {
		logic [1:0] bom_kind;
		logic       may_be_utf16_be;
		logic       may_be_utf16_le;
		logic       may_be_utf8;
		logic       may_be_dbcs;
	} verdict_t;

endpackage

// File: sv/tes_utf16_lane.sv
module tes_utf16_lane (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        clear,
	input  logic        unit_en,
	input  logic [15:0] unit,
	input  logic        bad_pair,
	output logic        pass
);
	import tes_pkg::*;

	logic need_q;
	logic ok_q;
	logic need_n;
	logic ok_n;
	logic high_sur;
	logic low_sur;

	assign high_sur = (unit >= HIGH_SUR_LO) && (unit <= HIGH_SUR_HI);
	assign low_sur  = (unit >= LOW_SUR_LO) && (unit <= LOW_SUR_HI);

	always_comb begin
		need_n = need_q;
		ok_n   = ok_q;
		if (unit_en) begin
			if (bad_pair || unit == NON_CHAR)
				ok_n = 1'b0;
			if (need_q) begin
				if (low_sur)
					need_n = 1'b0;
				else
					ok_n = 1'b0;
			end else if (high_sur) begin
				need_n = 1'b1;
			end else if (low_sur) begin
				ok_n = 1'b0;
			end
		end
	end

	// a lane only passes on a whole number of units; the caller gates that
	assign pass = ok_n & ~need_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= 1'b0;
			ok_q   <= 1'b1;
		end else if (step) begin
			if (clear) begin
				need_q <= 1'b0;
				ok_q   <= 1'b1;
			end else begin
				need_q <= need_n;
				ok_q   <= ok_n;
			end
		end
	end

endmodule

// File: sv/tes_scan.sv
module tes_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              last,
	input  logic [7:0]        data,
	output tes_pkg::verdict_t verdict
);
	import tes_pkg::*;

	logic       dbcs_need_q, dbcs_ok_q;
	logic       dbcs_need_n, dbcs_ok_n;
	logic [2:0] utf8_pend_q, utf8_pend_n;
	logic       utf8_ok_q, utf8_ok_n;
	logic [7:0] held_q;
	logic       odd_q;
	logic [1:0] head_cnt_q, head_cnt_n;
	logic [2:0] head_flags_q, head_flags_n;
	logic       le_pass, be_pass;
	logic [1:0] kind;

	// double-byte: a byte of 0x80 or above opens a pair
	always_comb begin
		dbcs_ok_n   = dbcs_ok_q & (data != 8'd0);
		dbcs_need_n = dbcs_need_q ? 1'b0 : data[7];
	end

	always_comb begin
		utf8_ok_n   = utf8_ok_q;
		utf8_pend_n = utf8_pend_q;
		if (utf8_pend_q != 3'd0) begin
			if ((data & CONT_MASK) != CONT_BITS)
				utf8_ok_n = 1'b0;
			utf8_pend_n = utf8_pend_q - 3'd1;
		end else if (data == 8'd0) begin
			utf8_ok_n = 1'b0;
		end else if (data inside {[8'hC0:8'hDF]}) begin
			utf8_pend_n = 3'd1;
		end else if (data inside {[8'hE0:8'hEF]}) begin
			utf8_pend_n = 3'd2;
		end else if (data inside {[8'hF0:8'hF7]}) begin
			utf8_pend_n = 3'd3;
		end else if (data inside {[8'hF8:8'hFB]}) begin
			utf8_pend_n = 3'd4;
		end else if (data inside {[8'hFC:8'hFD]}) begin
			utf8_pend_n = 3'd5;
		end
	end

	// UTF-16 units complete on the odd byte
	tes_utf16_lane u_le (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.clear    (last),
		.unit_en  (odd_q),
		.unit     ({data, held_q}),
		.bad_pair (held_q[7] && data == 8'd0),
		.pass     (le_pass)
	);

	tes_utf16_lane u_be (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.clear    (last),
		.unit_en  (odd_q),
		.unit     ({held_q, data}),
		.bad_pair (data[7] && held_q == 8'd0),
		.pass     (be_pass)
	);

	// bit 0 UTF-8 mark, bit 1 LE mark, bit 2 BE mark
	always_comb begin
		head_flags_n = head_flags_q;
		case (head_cnt_q)
			2'd0: begin
				if (data != BOM8_B0) head_flags_n[0] = 1'b0;
				if (data != BYTE_FF) head_flags_n[1] = 1'b0;
				if (data != BYTE_FE) head_flags_n[2] = 1'b0;
			end
			2'd1: begin
				if (data != BOM8_B1) head_flags_n[0] = 1'b0;
				if (data != BYTE_FE) head_flags_n[1] = 1'b0;
				if (data != BYTE_FF) head_flags_n[2] = 1'b0;
			end
			2'd2: begin
				if (data != BOM8_B2) head_flags_n[0] = 1'b0;
			end
			default: ;
		endcase
		head_cnt_n = (head_cnt_q == 2'd3) ? head_cnt_q : head_cnt_q + 2'd1;
	end

	always_comb begin
		kind = BOM_NONE;
		if (head_cnt_n == 2'd3 && head_flags_n[0])
			kind = BOM_UTF8;
		else if (head_cnt_n >= 2'd2 && head_flags_n[1])
			kind = BOM_LE;
		else if (head_cnt_n >= 2'd2 && head_flags_n[2])
			kind = BOM_BE;
	end

	always_comb begin
		verdict.may_be_dbcs     = dbcs_ok_n & ~dbcs_need_n;
		verdict.may_be_utf8     = utf8_ok_n & (utf8_pend_n == 3'd0);
		verdict.may_be_utf16_le = le_pass & odd_q;
		verdict.may_be_utf16_be = be_pass & odd_q;
		verdict.bom_kind        = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbcs_need_q  <= 1'b0;
			dbcs_ok_q    <= 1'b1;
			utf8_pend_q  <= 3'd0;
			utf8_ok_q    <= 1'b1;
			held_q       <= 8'd0;
			odd_q        <= 1'b0;
			head_cnt_q   <= 2'd0;
			head_flags_q <= 3'b111;
		end else if (step) begin
			if (last) begin
				// drop back to the start-of-buffer state
				dbcs_need_q  <= 1'b0;
				dbcs_ok_q    <= 1'b1;
				utf8_pend_q  <= 3'd0;
				utf8_ok_q    <= 1'b1;
				held_q       <= 8'd0;
				odd_q        <= 1'b0;
				head_cnt_q   <= 2'd0;
				head_flags_q <= 3'b111;
			end else begin
				dbcs_need_q  <= dbcs_need_n;
				dbcs_ok_q    <= dbcs_ok_n;
				utf8_pend_q  <= utf8_pend_n;
				utf8_ok_q    <= utf8_ok_n;
				if (!odd_q)
					held_q <= data;
				odd_q        <= ~odd_q;
				head_cnt_q   <= head_cnt_n;
				head_flags_q <= head_flags_n;
			end
		end
	end

endmodule

// File: sv/text_encoding_sniffer.sv
// Pipeline: two register stages; the final byte of a buffer is held in the input stage, and its
// verdict is registered into the result register once that register has room.
// Throughput: one byte per cycle; the scan state is updated once per byte in one stage.
// The input stage stalls only when a verdict is waiting behind an unread result.
// Reset (arst_n low, asynchronous) empties both stages and restarts the buffer scan;
// the scan also returns to its start state after every final byte.
module text_encoding_sniffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] may_be_dbcs, [1] may_be_utf8, [2] may_be_utf16_le,
	                              // [3] may_be_utf16_be, [5:4] bom_kind, [7:6] zero
);
	import tes_pkg::*;

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] data_s1;
	logic       out_free;
	logic       adv_s1;
	logic       step;
	verdict_t   verdict;
	verdict_t   result_q;

	assign out_free = ~m_tvalid | m_tready;
	// only a final byte needs room in the result register
	assign adv_s1   = ~last_s1 | out_free;
	assign s_tready = ~valid_s1 | adv_s1;
	assign step     = valid_s1 & adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	tes_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.last    (last_s1),
		.data    (data_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (step && last_s1)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && last_s1)
			result_q <= verdict;
	end

	assign m_tdata = {2'b00, result_q};

`include "assert_macros.svh"

	`TES_ASSERT_IMP(a_out_from_final, $rose(m_tvalid), $past(valid_s1 && last_s1))
	`TES_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && last_s1 && m_tvalid && !m_tready)
	`TES_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready && valid_s1 && last_s1, !step)

endmodule

// File: bench/tes_checker.sv
`timescale 1ns / 100ps

module tes_checker
	import tes_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	output int         fail_count,
	output int         outstanding,
	output int         verdicts_checked
);

	// bit positions in mark_live
	localparam int MARK_UTF8 = 0;
	localparam int MARK_LE   = 1;
	localparam int MARK_BE   = 2;

	// scan state of the predicted sniffer
	logic       dbcs_trail_due;
	logic       dbcs_clean;
	logic [2:0] cont_left;
	logic       utf8_clean;
	logic [7:0] even_byte;
	logic       odd_pos;
	logic       le_low_due;
	logic       le_clean;
	logic       be_low_due;
	logic       be_clean;
	logic [1:0] lead_seen;
	logic [2:0] mark_live;

	verdict_t verdict_q[$];

	initial begin
		fail_count       = 0;
		outstanding      = 0;
		verdicts_checked = 0;
	end

	task automatic note_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] seen);
		fail_count++;
		if (fail_count <= 60)
			$display("%0t ns  verdict %0d  %s: expected 'h%h, got 'h%h",
				$time, verdicts_checked, what, want, seen);
	endtask

	task automatic clear_scan();
		dbcs_trail_due = 1'b0;
		dbcs_clean     = 1'b1;
		cont_left      = 3'd0;
		utf8_clean     = 1'b1;
		even_byte      = 8'h00;
		odd_pos        = 1'b0;
		le_low_due     = 1'b0;
		le_clean       = 1'b1;
		be_low_due     = 1'b0;
		be_clean       = 1'b1;
		lead_seen      = 2'd0;
		mark_live      = 3'b111;
	endtask

	// One complete 16-bit unit: surrogate pairing and forbidden values.
	task automatic utf16_unit(input logic [15:0] unit, input logic bad_pair,
			inout logic low_due, inout logic clean);
		logic high_sur;
		logic low_sur;
		high_sur = unit >= HIGH_SUR_LO && unit <= HIGH_SUR_HI;
		low_sur  = unit >= LOW_SUR_LO && unit <= LOW_SUR_HI;
		if (bad_pair || unit == NON_CHAR)
			clean = 1'b0;
		if (low_due) begin
			if (low_sur)
				low_due = 1'b0;
			else
				clean = 1'b0;
		end else if (high_sur) begin
			low_due = 1'b1;
		end else if (low_sur) begin
			clean = 1'b0;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic fin);
		verdict_t v;
		if (b == 8'h00)
			dbcs_clean = 1'b0;
		if (dbcs_trail_due)
			dbcs_trail_due = 1'b0;
		else if (b[7])
			dbcs_trail_due = 1'b1;

		if (cont_left != 3'd0) begin
			if ((b & CONT_MASK) != CONT_BITS)
				utf8_clean = 1'b0;
			cont_left = cont_left - 3'd1;
		end else if (b == 8'h00) begin
			utf8_clean = 1'b0;
		end else if (b[7:5] == 3'b110) begin
			cont_left = 3'd1;
		end else if (b[7:4] == 4'b1110) begin
			cont_left = 3'd2;
		end else if (b[7:3] == 5'b11110) begin
			cont_left = 3'd3;
		end else if (b[7:2] == 6'b111110) begin
			cont_left = 3'd4;
		end else if (b[7:1] == 7'b1111110) begin
			cont_left = 3'd5;
		end

		if (odd_pos) begin
			utf16_unit({b, even_byte}, even_byte[7] && b == 8'h00, le_low_due, le_clean);
			utf16_unit({even_byte, b}, b[7] && even_byte == 8'h00, be_low_due, be_clean);
			odd_pos = 1'b0;
		end else begin
			even_byte = b;
			odd_pos   = 1'b1;
		end

		case (lead_seen)
			2'd0: begin
				if (b != BOM8_B0) mark_live[MARK_UTF8] = 1'b0;
				if (b != BYTE_FF) mark_live[MARK_LE]   = 1'b0;
				if (b != BYTE_FE) mark_live[MARK_BE]   = 1'b0;
			end
			2'd1: begin
				if (b != BOM8_B1) mark_live[MARK_UTF8] = 1'b0;
				if (b != BYTE_FE) mark_live[MARK_LE]   = 1'b0;
				if (b != BYTE_FF) mark_live[MARK_BE]   = 1'b0;
			end
			2'd2: begin
				if (b != BOM8_B2) mark_live[MARK_UTF8] = 1'b0;
			end
			default: ;
		endcase
		if (lead_seen != 2'd3)
			lead_seen = lead_seen + 2'd1;

		if (fin) begin
			if (lead_seen == 2'd3 && mark_live[MARK_UTF8])
				v.bom_kind = BOM_UTF8;
			else if (lead_seen >= 2'd2 && mark_live[MARK_LE])
				v.bom_kind = BOM_LE;
			else if (lead_seen >= 2'd2 && mark_live[MARK_BE])
				v.bom_kind = BOM_BE;
			else
				v.bom_kind = BOM_NONE;
			v.may_be_dbcs     = dbcs_clean && !dbcs_trail_due;
			v.may_be_utf8     = utf8_clean && cont_left == 3'd0;
			v.may_be_utf16_le = le_clean && !le_low_due && !odd_pos;
			v.may_be_utf16_be = be_clean && !be_low_due && !odd_pos;
			verdict_q.push_back(v);
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t seen;
		if (!arst_n) begin
			clear_scan();
			verdict_q.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = verdict_t'(m_tdata[5:0]);
				if (verdict_q.size() == 0) begin
					note_mismatch("verdict with nothing expected", 8'h00, m_tdata);
				end else begin
					want = verdict_q.pop_front();
					if (seen.may_be_dbcs !== want.may_be_dbcs)
						note_mismatch("may_be_dbcs", 8'(want.may_be_dbcs),
							8'(seen.may_be_dbcs));
					if (seen.may_be_utf8 !== want.may_be_utf8)
						note_mismatch("may_be_utf8", 8'(want.may_be_utf8),
							8'(seen.may_be_utf8));
					if (seen.may_be_utf16_le !== want.may_be_utf16_le)
						note_mismatch("may_be_utf16_le", 8'(want.may_be_utf16_le),
							8'(seen.may_be_utf16_le));
					if (seen.may_be_utf16_be !== want.may_be_utf16_be)
						note_mismatch("may_be_utf16_be", 8'(want.may_be_utf16_be),
							8'(seen.may_be_utf16_be));
					if (seen.bom_kind !== want.bom_kind)
						note_mismatch("bom_kind", 8'(want.bom_kind), 8'(seen.bom_kind));
					if (m_tdata[7:6] !== 2'b00)
						note_mismatch("tdata padding", 8'h00, 8'(m_tdata[7:6]));
				end
				verdicts_checked++;
			end
			if (s_tvalid && s_tready)
				scan_byte(s_tdata, s_tlast);
			outstanding <= verdict_q.size();
		end
	end

endmodule

// File: bench/tb_text_encoding_sniffer.sv
`timescale 1ns / 100ps

module tb_text_encoding_sniffer;
	import tes_pkg::*;

	localparam int BYTE_TARGET = 1150;
	localparam int QUIET_LIMIT = 4000;
	localparam int OPENING_LEN = 23;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	int fail_count;
	int outstanding;
	int verdicts_checked;
	int bytes_sent;
	int buffers_sent;
	int quiet_cycles;
	bit calm;

	logic [7:0] text_q[$];

	text_encoding_sniffer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tes_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.verdicts_checked (verdicts_checked)
	);

	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one; none at all in calm stretches
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Directed buffers: marks of each kind, two-byte and one-byte buffers,
	// zero and 0xFF bytes, zero inside a UTF-8 sequence, a surrogate pair,
	// a cut-off sequence, a stray continuation byte with odd length, 0xFFFF.
	function automatic logic [8:0] opening_byte(input int idx);
		case (idx)
			0:  return {1'b0, 8'hEF};
			1:  return {1'b0, 8'hBB};
			2:  return {1'b0, 8'hBF};
			3:  return {1'b1, 8'h41};
			4:  return {1'b0, 8'hFF};
			5:  return {1'b1, 8'hFE};
			6:  return {1'b0, 8'hFE};
			7:  return {1'b1, 8'hFF};
			8:  return {1'b1, 8'h00};
			9:  return {1'b1, 8'hFF};
			10: return {1'b0, 8'hC3};
			11: return {1'b1, 8'h00};
			12: return {1'b0, 8'h3D};
			13: return {1'b0, 8'hD8};
			14: return {1'b0, 8'h00};
			15: return {1'b1, 8'hDC};
			16: return {1'b0, 8'hE2};
			17: return {1'b1, 8'h82};
			18: return {1'b0, 8'h41};
			19: return {1'b0, 8'h80};
			20: return {1'b1, 8'h42};
			21: return {1'b0, 8'hFF};
			default: return {1'b1, 8'hFF};
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		if (fin)
			buffers_sent++;
	endtask

	// hold the input until every verdict owed has been read out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic add_utf8_char();
		int r;
		int len;
		logic [7:0] lead;
		r = $urandom_range(0, 99);
		len = r < 40 ? 1 : r < 65 ? 2 : r < 82 ? 3 : r < 92 ? 4 : r < 96 ? 5 : 6;
		case (len)
			1: lead = 8'($urandom_range(8'h01, 8'h7F));
			2: lead = 8'hC0 | 8'($urandom_range(0, 31));
			3: lead = 8'hE0 | 8'($urandom_range(0, 15));
			4: lead = 8'hF0 | 8'($urandom_range(0, 7));
			5: lead = 8'hF8 | 8'($urandom_range(0, 3));
			default: lead = 8'hFC | 8'($urandom_range(0, 1));
		endcase
		text_q.push_back(lead);
		repeat (len - 1) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	task automatic add_utf16_unit(input bit big_end);
		int r;
		int n;
		logic [15:0] units[2];
		r = $urandom_range(0, 99);
		n = 1;
		if (r < 45) begin
			units[0] = 16'($urandom_range(16'h0020, 16'h007E));
		end else if (r < 78) begin
			units[0] = 16'($urandom_range(16'h0100, 16'hD7FF));
		end else if (r < 93) begin
			units[0] = 16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI));
			units[1] = 16'($urandom_range(LOW_SUR_LO, LOW_SUR_HI));
			n = 2;
		end else begin
			units[0] = 16'($urandom_range(0, 16'hFFFF));
		end
		for (int i = 0; i < n; i++) begin
			if (big_end) begin
				text_q.push_back(units[i][15:8]);
				text_q.push_back(units[i][7:0]);
			end else begin
				text_q.push_back(units[i][7:0]);
				text_q.push_back(units[i][15:8]);
			end
		end
	endtask

	task automatic add_dbcs_char();
		if ($urandom_range(0, 99) < 55) begin
			text_q.push_back(8'($urandom_range(8'h01, 8'h7F)));
		end else begin
			text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
			text_q.push_back(8'($urandom_range(8'h01, 8'hFF)));
		end
	endtask

	// noise leans on the mark bytes, zero and 0xFF so that partial marks turn up
	task automatic add_noise_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			text_q.push_back(8'h00);
		else if (r < 20)
			text_q.push_back(BYTE_FF);
		else if (r < 28)
			text_q.push_back(BYTE_FE);
		else if (r < 34)
			text_q.push_back(BOM8_B0);
		else if (r < 38)
			text_q.push_back(BOM8_B1);
		else if (r < 42)
			text_q.push_back(BOM8_B2);
		else
			text_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_buffer();
		int family;
		int chars;
		int idx;
		text_q.delete();
		family = $urandom_range(0, 99);
		chars  = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
		if (family < 25) begin
			if ($urandom_range(0, 2) == 0) begin
				text_q.push_back(BOM8_B0);
				text_q.push_back(BOM8_B1);
				text_q.push_back(BOM8_B2);
			end
			repeat (chars) add_utf8_char();
		end else if (family < 45) begin
			if ($urandom_range(0, 1) == 0) begin
				text_q.push_back(BYTE_FF);
				text_q.push_back(BYTE_FE);
			end
			repeat (chars) add_utf16_unit(1'b0);
		end else if (family < 65) begin
			if ($urandom_range(0, 1) == 0) begin
				text_q.push_back(BYTE_FE);
				text_q.push_back(BYTE_FF);
			end
			repeat (chars) add_utf16_unit(1'b1);
		end else if (family < 80) begin
			repeat (chars) add_dbcs_char();
		end else begin
			repeat (chars) add_noise_byte();
		end

		// break a fifth of the buffers
		if ($urandom_range(0, 4) == 0) begin
			idx = $urandom_range(0, text_q.size() - 1);
			case ($urandom_range(0, 3))
				0: text_q[idx] = 8'($urandom_range(0, 255));
				1: if (text_q.size() > 1) void'(text_q.pop_back());
				2: text_q.push_back(8'($urandom_range(0, 255)));
				default: text_q[idx] = 8'h00;
			endcase
		end
	endtask

	initial begin
		logic [8:0] ob;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		calm     = 1'b0;
		bytes_sent   = 0;
		buffers_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < OPENING_LEN; i++) begin
			ob = opening_byte(i);
			send_byte(ob[7:0], ob[8]);
		end
		wait_drained();

		while (bytes_sent < BYTE_TARGET) begin
			calm = ((buffers_sent / 16) % 5) == 4;
			if (buffers_sent == 60 || buffers_sent == 130)
				wait_drained();
			build_buffer();
			foreach (text_q[i])
				send_byte(text_q[i], i == text_q.size() - 1);
		end
		calm = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d buffers, %0d bytes; %0d verdicts compared field by field.",
			buffers_sent, bytes_sent, verdicts_checked);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stalls, with runs of ready in between
	initial begin
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = idle_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// count cycles without any transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Stalled for %0d cycles with %0d verdicts owed.",
				quiet_cycles, outstanding);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
